@@ src/assert_macros.svh @@
// Assertion macros shared by the track table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define NN_ASSERT_IMP(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("assertion violated");

// Next-cycle implication, disabled while reset is asserted.
`define NN_ASSERT_NXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("assertion violated");

`endif

@@ src/nntt_pkg.sv @@
// Package with shared constants, codes and control types of the track table.
`timescale 1ns / 1ps
package nntt_pkg;

	localparam int MAX_TRACKS_DEF = 16;
	localparam int COORD_BITS_DEF = 16;
	localparam int MAX_RESULTS    = 16;

	localparam int ID_W       = 32;
	localparam int TICK_W     = 32;
	localparam int RADIUS_W   = 34;
	localparam int AGE_W      = 16;
	localparam int ACT_W      = 2;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 34;

	localparam logic [ACT_W-1:0] ACT_DETECT = 2'd0;
	localparam logic [ACT_W-1:0] ACT_TICK   = 2'd1;
	localparam logic [ACT_W-1:0] ACT_REPORT = 2'd2;

	localparam logic [KIND_W-1:0] KIND_MATCHED  = 3'd0;
	localparam logic [KIND_W-1:0] KIND_NEW      = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DROPPED  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_REPORTED = 3'd3;
	localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STALE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RECENT = 2'd2;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 34'd65536;
	localparam logic [AGE_W-1:0]    STALE_RST  = 16'd200;
	localparam logic [AGE_W-1:0]    RECENT_RST = 16'd50;

	typedef struct packed {
		logic load;
		logic scan;
		logic rd_en;
		logic det_commit;
		logic rep_keep;
		logic rep_hold;
		logic rep_finish;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic keep;
		logic recent;
		logic held_v;
		logic out_free;
	} sts_t;

endpackage

@@ src/nntt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module nntt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/nntt_dp.sv @@
// Datapath: track RAM, distance pipeline, table state, config and output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nntt_dp #(
	parameter int MAX_TRACKS = 16,
	parameter int COORD_BITS = 16,
	parameter int CW         = $clog2(MAX_TRACKS + 1)
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic [nntt_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [nntt_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic [nntt_pkg::ACT_W-1:0]           action,
	input  logic signed [COORD_BITS-1:0]         pos_x,
	input  logic signed [COORD_BITS-1:0]         pos_y,
	input  logic signed [COORD_BITS-1:0]         pos_z,
	input  logic                                 end_of_batch,
	input  nntt_pkg::cmd_t                       cmd,
	input  logic [CW-1:0]                        rd_idx,
	input  logic [CW-1:0]                        wr_idx,
	output nntt_pkg::sts_t                       sts,
	output logic [CW-1:0]                        count,
	input  logic                                 out_ready,
	output logic                                 out_valid,
	output logic [nntt_pkg::KIND_W-1:0]          kind,
	output logic [nntt_pkg::ID_W-1:0]            track_id,
	output logic signed [COORD_BITS-1:0]         out_x,
	output logic signed [COORD_BITS-1:0]         out_y,
	output logic signed [COORD_BITS-1:0]         out_z,
	output logic [nntt_pkg::TICK_W-1:0]          first_tick,
	output logic [nntt_pkg::TICK_W-1:0]          last_tick,
	output logic                                 last
);
	import nntt_pkg::*;

	localparam int AW     = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int C      = COORD_BITS;
	localparam int OFF_LAST  = 0;
	localparam int OFF_FIRST = TICK_W;
	localparam int OFF_Z     = 2 * TICK_W;
	localparam int OFF_Y     = OFF_Z + C;
	localparam int OFF_X     = OFF_Y + C;
	localparam int OFF_ID    = OFF_X + C;
	localparam int WW        = OFF_ID + ID_W;
	localparam int SQW       = 2 * C + 2;
	localparam int SUMW      = SQW + 2;
	localparam int CMPW      = (SUMW > RADIUS_W) ? SUMW : RADIUS_W;

	logic [RADIUS_W-1:0] radius_q;
	logic [AGE_W-1:0]    stale_q;
	logic [AGE_W-1:0]    recent_q;

	logic [C-1:0]        px_q, py_q, pz_q;
	logic                eob_q;
	logic [CW-1:0]       count_q;
	logic [ID_W-1:0]     next_id_q;
	logic [TICK_W-1:0]   now_q;
	logic [MAX_TRACKS-1:0] pending_q;
	logic [MAX_TRACKS-1:0] above;

	logic                ram_we;
	logic [AW-1:0]       ram_waddr;
	logic [WW-1:0]       ram_wdata;
	logic [WW-1:0]       rdata;

	logic                vld_s1;
	logic [AW-1:0]       idx_s1;
	logic                vld_s2;
	logic [AW-1:0]       idx_s2;
	logic [WW-1:0]       word_s2;
	logic [SQW-1:0]      sqx_s2, sqy_s2, sqz_s2;

	logic signed [C:0]     dx, dy, dz;
	logic signed [SQW-1:0] sqx, sqy, sqz;
	logic [SUMW-1:0]       dist_sum;
	logic [CMPW-1:0]       dist_c, best_c;

	logic                found_q;
	logic [RADIUS_W-1:0] best_q;
	logic [AW-1:0]       bidx_q;
	logic [WW-1:0]       bword_q;

	logic                held_v_q;
	logic [WW-1:0]       held_q;

	logic [TICK_W-1:0]   age;
	logic [WW-1:0]       det_word;
	logic                full;

	logic                out_valid_q;
	logic                load_out;
	logic [KIND_W-1:0]   kind_q, kind_d;
	logic [ID_W-1:0]     id_q, id_d;
	logic [C-1:0]        x_q, x_d, y_q, y_d, z_q, z_d;
	logic [TICK_W-1:0]   first_q, first_d, lastt_q, lastt_d;
	logic                fin_q, fin_d;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RST;
			stale_q  <= STALE_RST;
			recent_q <= RECENT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_RADIUS: radius_q <= cfg_data;
				CFG_STALE:  stale_q  <= cfg_data[AGE_W-1:0];
				CFG_RECENT: recent_q <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	assign full = (count_q == CW'(MAX_TRACKS));

	// track storage
	assign det_word = {found_q ? bword_q[OFF_ID +: ID_W] : next_id_q,
		px_q, py_q, pz_q,
		found_q ? bword_q[OFF_FIRST +: TICK_W] : now_q,
		now_q};
	assign ram_we    = cmd.rep_keep || (cmd.det_commit && (found_q || !full));
	assign ram_waddr = cmd.rep_keep ? wr_idx[AW-1:0] : (found_q ? bidx_q : count_q[AW-1:0]);
	assign ram_wdata = cmd.rep_keep ? rdata : det_word;

	nntt_ram #(
		.WIDTH (WW),
		.DEPTH (MAX_TRACKS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (rd_idx[AW-1:0]),
		.rdata (rdata)
	);

	// distance pipeline
	assign dx  = $signed({px_q[C-1], px_q}) - $signed({rdata[OFF_X+C-1], rdata[OFF_X +: C]});
	assign dy  = $signed({py_q[C-1], py_q}) - $signed({rdata[OFF_Y+C-1], rdata[OFF_Y +: C]});
	assign dz  = $signed({pz_q[C-1], pz_q}) - $signed({rdata[OFF_Z+C-1], rdata[OFF_Z +: C]});
	assign sqx = dx * dx;
	assign sqy = dy * dy;
	assign sqz = dz * dz;
	assign dist_sum = {2'b00, sqx_s2} + {2'b00, sqy_s2} + {2'b00, sqz_s2};
	assign dist_c   = CMPW'(dist_sum);
	assign best_c   = CMPW'(best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.rd_en && cmd.scan;
			vld_s2 <= vld_s1 && !pending_q[idx_s1];
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx[AW-1:0];
		idx_s2  <= idx_s1;
		word_s2 <= rdata;
		sqx_s2  <= $unsigned(sqx);
		sqy_s2  <= $unsigned(sqy);
		sqz_s2  <= $unsigned(sqz);
	end

	// nearest candidate, earlier entry wins a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
		end else if (vld_s2 && dist_c < best_c) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			best_q <= radius_q;
		end else if (vld_s2 && dist_c < best_c) begin
			best_q  <= dist_c[RADIUS_W-1:0];
			bidx_q  <= idx_s2;
			bword_q <= word_s2;
		end
	end

	// request latch
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q  <= pos_x;
			py_q  <= pos_y;
			pz_q  <= pos_z;
			eob_q <= end_of_batch;
		end
	end

	// table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			next_id_q <= '0;
			now_q     <= '0;
			pending_q <= '0;
		end else begin
			if (cmd.load && (action == ACT_TICK || action == ACT_REPORT)) begin
				pending_q <= '0;
			end
			if (cmd.load && action == ACT_TICK) begin
				now_q <= now_q + 1'b1;
			end
			if (cmd.det_commit) begin
				if (eob_q) begin
					pending_q <= '0;
				end else if (!found_q && !full) begin
					pending_q[count_q[AW-1:0]] <= 1'b1;
				end
				if (!found_q && !full) begin
					count_q   <= count_q + 1'b1;
					next_id_q <= next_id_q + 1'b1;
				end
			end
			if (cmd.rep_finish) begin
				count_q <= wr_idx;
			end
		end
	end

	// report hold stage
	assign age = now_q - rdata[OFF_LAST +: TICK_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_v_q <= 1'b0;
		end else if (cmd.rep_hold) begin
			held_v_q <= 1'b1;
		end else if (cmd.rep_finish) begin
			held_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rep_hold) begin
			held_q <= rdata;
		end
	end

	// result register
	assign load_out = cmd.det_commit || (cmd.rep_hold && held_v_q) || cmd.rep_finish;

	always_comb begin
		kind_d  = KIND_MATCHED;
		id_d    = det_word[OFF_ID +: ID_W];
		x_d     = px_q;
		y_d     = py_q;
		z_d     = pz_q;
		first_d = det_word[OFF_FIRST +: TICK_W];
		lastt_d = now_q;
		fin_d   = 1'b1;
		if (cmd.det_commit) begin
			if (found_q) begin
				kind_d = KIND_MATCHED;
			end else if (!full) begin
				kind_d = KIND_NEW;
			end else begin
				kind_d  = KIND_DROPPED;
				id_d    = '0;
				first_d = now_q;
			end
		end else if (held_v_q) begin
			kind_d  = KIND_REPORTED;
			id_d    = held_q[OFF_ID +: ID_W];
			x_d     = held_q[OFF_X +: C];
			y_d     = held_q[OFF_Y +: C];
			z_d     = held_q[OFF_Z +: C];
			first_d = held_q[OFF_FIRST +: TICK_W];
			lastt_d = held_q[OFF_LAST +: TICK_W];
			fin_d   = cmd.rep_finish;
		end else begin
			kind_d  = KIND_EMPTY;
			id_d    = '0;
			x_d     = '0;
			y_d     = '0;
			z_d     = '0;
			first_d = '0;
			lastt_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			kind_q  <= kind_d;
			id_q    <= id_d;
			x_q     <= x_d;
			y_q     <= y_d;
			z_q     <= z_d;
			first_q <= first_d;
			lastt_q <= lastt_d;
			fin_q   <= fin_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign track_id   = id_q;
	assign out_x      = x_q;
	assign out_y      = y_q;
	assign out_z      = z_q;
	assign first_tick = first_q;
	assign last_tick  = lastt_q;
	assign last       = fin_q;

	assign count        = count_q;
	assign sts.full     = full;
	assign sts.keep     = age < TICK_W'(stale_q);
	assign sts.recent   = age < TICK_W'(recent_q);
	assign sts.held_v   = held_v_q;
	assign sts.out_free = !out_valid_q || out_ready;

	always_comb begin
		for (int j = 0; j < MAX_TRACKS; j++) begin
			above[j] = (j >= int'(count_q));
		end
	end

	`NN_ASSERT_IMP(a_count_bound, clk, arst_n, 1'b1, count_q <= CW'(MAX_TRACKS))
	`NN_ASSERT_IMP(a_pending_in_table, clk, arst_n, 1'b1, (pending_q & above) == '0)
	`NN_ASSERT_IMP(a_commit_room, clk, arst_n, load_out, !out_valid_q || out_ready)

endmodule

@@ src/nntt_ctrl.sv @@
// Controller: sequences detection scans, report compaction and result hand-off.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module nntt_ctrl #(
	parameter int MAX_TRACKS = 16,
	parameter int CW         = $clog2(MAX_TRACKS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [nntt_pkg::ACT_W-1:0] action,
	input  nntt_pkg::sts_t             sts,
	input  logic [CW-1:0]              count,
	output nntt_pkg::cmd_t             cmd,
	output logic [CW-1:0]              rd_idx,
	output logic [CW-1:0]              wr_idx
);
	import nntt_pkg::*;

	localparam int KW = $clog2(MAX_RESULTS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DSCAN,
		S_DWAIT,
		S_DCOMMIT,
		S_RRD,
		S_REV,
		S_REND
	} state_t;

	state_t        state_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] w_q;
	logic [KW-1:0] k_q;
	logic          need;
	logic          stall;

	assign need  = sts.keep && sts.recent && (k_q < KW'(MAX_RESULTS));
	assign stall = need && sts.held_v && !sts.out_free;

	always_comb begin
		cmd      = '0;
		rd_idx   = i_q;
		wr_idx   = w_q;
		in_ready = (state_q == S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
			end
			S_DSCAN: begin
				cmd.scan  = 1'b1;
				cmd.rd_en = (i_q < count);
			end
			S_DWAIT: ;
			S_DCOMMIT: begin
				cmd.det_commit = sts.out_free;
			end
			S_RRD: begin
				cmd.rd_en = (i_q < count);
			end
			S_REV: begin
				if (!stall) begin
					cmd.rep_keep = sts.keep;
					cmd.rep_hold = need;
				end
			end
			S_REND: begin
				cmd.rep_finish = sts.out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q     <= '0;
			w_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					i_q <= '0;
					w_q <= '0;
					k_q <= '0;
					if (in_valid) begin
						unique case (action)
							ACT_DETECT: state_q <= S_DSCAN;
							ACT_REPORT: state_q <= S_RRD;
							default:    state_q <= S_IDLE;
						endcase
					end
				end
				S_DSCAN: begin
					if (i_q < count) begin
						i_q <= i_q + 1'b1;
					end else begin
						state_q <= S_DWAIT;
					end
				end
				S_DWAIT: state_q <= S_DCOMMIT;
				S_DCOMMIT: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_RRD: begin
					state_q <= (i_q < count) ? S_REV : S_REND;
				end
				S_REV: begin
					if (!stall) begin
						i_q     <= i_q + 1'b1;
						w_q     <= w_q + CW'(sts.keep);
						k_q     <= k_q + KW'(need);
						state_q <= S_RRD;
					end
				end
				S_REND: begin
					if (sts.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`NN_ASSERT_IMP(a_result_bound, clk, arst_n, 1'b1, k_q <= KW'(MAX_RESULTS))
	`NN_ASSERT_NXT(a_commit_done, clk, arst_n, cmd.det_commit || cmd.rep_finish, in_ready)

endmodule

@@ src/nearest_neighbor_track_table_top.sv @@
// Top level of the nearest-neighbor track table.
`timescale 1ns / 1ps
// A detection scans the table one entry per cycle through the single track RAM
// port and a three-stage distance pipeline, then loads its result. A report
// reads and compacts the table in place, one entry after another, with any wait
// on the result register. A tick advances the time on acceptance. A new request is
// accepted only when the previous one is finished, while its last result may
// still wait in the output register.
module nearest_neighbor_track_table_top #(
	parameter int MAX_TRACKS = nntt_pkg::MAX_TRACKS_DEF,
	parameter int COORD_BITS = nntt_pkg::COORD_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [nntt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nntt_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [nntt_pkg::ACT_W-1:0]      action,
	input  logic signed [COORD_BITS-1:0]    pos_x,
	input  logic signed [COORD_BITS-1:0]    pos_y,
	input  logic signed [COORD_BITS-1:0]    pos_z,
	input  logic                            end_of_batch,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [nntt_pkg::KIND_W-1:0]     kind,
	output logic [nntt_pkg::ID_W-1:0]       track_id,
	output logic signed [COORD_BITS-1:0]    out_x,
	output logic signed [COORD_BITS-1:0]    out_y,
	output logic signed [COORD_BITS-1:0]    out_z,
	output logic [nntt_pkg::TICK_W-1:0]     first_tick,
	output logic [nntt_pkg::TICK_W-1:0]     last_tick,
	output logic                            last
);
	import nntt_pkg::*;

	localparam int CW = $clog2(MAX_TRACKS + 1);

	cmd_t          cmd;
	sts_t          sts;
	logic [CW-1:0] count;
	logic [CW-1:0] rd_idx;
	logic [CW-1:0] wr_idx;

	assign cfg_ready = 1'b1;

	nntt_ctrl #(
		.MAX_TRACKS (MAX_TRACKS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.action   (action),
		.sts      (sts),
		.count    (count),
		.cmd      (cmd),
		.rd_idx   (rd_idx),
		.wr_idx   (wr_idx)
	);

	nntt_dp #(
		.MAX_TRACKS (MAX_TRACKS),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.action       (action),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.pos_z        (pos_z),
		.end_of_batch (end_of_batch),
		.cmd          (cmd),
		.rd_idx       (rd_idx),
		.wr_idx       (wr_idx),
		.sts          (sts),
		.count        (count),
		.out_ready    (out_ready),
		.out_valid    (out_valid),
		.kind         (kind),
		.track_id     (track_id),
		.out_x        (out_x),
		.out_y        (out_y),
		.out_z        (out_z),
		.first_tick   (first_tick),
		.last_tick    (last_tick),
		.last         (last)
	);

endmodule

@@ sim/nntt_checker.sv @@
// Checker for the track table: predicts results from observed requests and compares them.
`timescale 1ns / 1ps
module nntt_checker
	import nntt_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [ACT_W-1:0]      action,
	input  logic signed [15:0]    pos_x,
	input  logic signed [15:0]    pos_y,
	input  logic signed [15:0]    pos_z,
	input  logic                  end_of_batch,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [KIND_W-1:0]     kind,
	input  logic [ID_W-1:0]       track_id,
	input  logic signed [15:0]    out_x,
	input  logic signed [15:0]    out_y,
	input  logic signed [15:0]    out_z,
	input  logic [TICK_W-1:0]     first_tick,
	input  logic [TICK_W-1:0]     last_tick,
	input  logic                  last,
	output int                    fail_count,
	output int                    pending_results
);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ID_W-1:0]   id;
		logic [15:0]       x;
		logic [15:0]       y;
		logic [15:0]       z;
		logic [TICK_W-1:0] first;
		logic [TICK_W-1:0] lastt;
		logic              fin;
	} result_t;

	typedef struct {
		logic [ID_W-1:0]   id;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic signed [15:0] z;
		logic [TICK_W-1:0] first;
		logic [TICK_W-1:0] lastt;
		logic              pend;
	} track_t;

	localparam int TRACKS = MAX_TRACKS_DEF;

	result_t        expected_q[$];
	track_t         tracks[TRACKS];
	int             count;
	logic [ID_W-1:0]   next_id;
	logic [TICK_W-1:0] now;
	logic [RADIUS_W-1:0] radius;
	logic [AGE_W-1:0]    stale;
	logic [AGE_W-1:0]    recent;

	assign pending_results = expected_q.size();

	function automatic logic [63:0] sq(logic signed [15:0] a, logic signed [15:0] b);
		logic signed [17:0] d;
		d = 18'(a) - 18'(b);
		return 64'(d * d);
	endfunction

	task automatic queue_result(result_t r);
		expected_q.insert(expected_q.size(), r);
	endtask

	task automatic close_batch();
		for (int i = 0; i < TRACKS; i++) tracks[i].pend = 1'b0;
	endtask

	task automatic associate(logic signed [15:0] px, logic signed [15:0] py,
			logic signed [15:0] pz, logic eob);
		logic [63:0] best;
		logic [63:0] d;
		int bi;
		bi = -1;
		best = 64'(radius);
		for (int i = 0; i < count; i++) begin
			if (!tracks[i].pend) begin
				d = sq(px, tracks[i].x) + sq(py, tracks[i].y) + sq(pz, tracks[i].z);
				if (d < best) begin
					best = d;
					bi = i;
				end
			end
		end
		if (bi >= 0) begin
			tracks[bi].x = px;
			tracks[bi].y = py;
			tracks[bi].z = pz;
			tracks[bi].lastt = now;
			queue_result({KIND_MATCHED, tracks[bi].id, px, py, pz,
				tracks[bi].first, now, 1'b1});
		end else if (count < TRACKS) begin
			tracks[count] = '{next_id, px, py, pz, now, now, 1'b1};
			queue_result({KIND_NEW, next_id, px, py, pz, now, now, 1'b1});
			next_id++;
			count++;
		end else begin
			queue_result({KIND_DROPPED, 32'd0, px, py, pz, now, now, 1'b1});
		end
		if (eob) close_batch();
	endtask

	task automatic list_recent();
		int w;
		int k;
		w = 0;
		k = 0;
		for (int i = 0; i < count; i++) begin
			if (32'(now - tracks[i].lastt) < 32'(stale)) begin
				tracks[w] = tracks[i];
				w++;
			end
		end
		count = w;
		for (int i = 0; i < count && k < MAX_RESULTS; i++) begin
			if (32'(now - tracks[i].lastt) < 32'(recent)) begin
				queue_result({KIND_REPORTED, tracks[i].id, tracks[i].x,
					tracks[i].y, tracks[i].z, tracks[i].first, tracks[i].lastt, 1'b0});
				k++;
			end
		end
		if (k == 0) queue_result({KIND_EMPTY, 32'd0, 16'd0, 16'd0, 16'd0,
			32'd0, 32'd0, 1'b1});
		else expected_q[expected_q.size()-1].fin = 1'b1;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got;
		result_t exp_r;
		if (!arst_n) begin
			expected_q.delete();
			count = 0;
			next_id = '0;
			now = '0;
			radius = RADIUS_RST;
			stale = STALE_RST;
			recent = RECENT_RST;
			fail_count = 0;
			close_batch();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_RADIUS: radius = cfg_data;
					CFG_STALE: stale = cfg_data[AGE_W-1:0];
					CFG_RECENT: recent = cfg_data[AGE_W-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = {kind, track_id, out_x, out_y, out_z, first_tick, last_tick, last};
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %p", $time, got);
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (got !== exp_r) begin
						$display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready) begin
				case (action)
					ACT_DETECT: associate(pos_x, pos_y, pos_z, end_of_batch);
					ACT_TICK: begin
						close_batch();
						now++;
					end
					ACT_REPORT: begin
						close_batch();
						list_recent();
					end
					default: ;
				endcase
			end
		end
	end

endmodule

@@ sim/nearest_neighbor_track_table_top_tb.sv @@
// Testbench top for the track table: drives requests and configuration and gives the verdict.
`timescale 1ns / 1ps
module nearest_neighbor_track_table_top_tb;
	import nntt_pkg::*;

	localparam int LIMIT = 400000;
	localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

	logic clk;
	logic arst_n;
	logic cfg_valid, cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid, in_ready;
	logic [ACT_W-1:0] action;
	logic signed [15:0] pos_x, pos_y, pos_z;
	logic end_of_batch;
	logic out_valid, out_ready;
	logic [KIND_W-1:0] kind;
	logic [ID_W-1:0] track_id;
	logic signed [15:0] out_x, out_y, out_z;
	logic [TICK_W-1:0] first_tick, last_tick;
	logic last;
	int fail_count;
	int pending_results;
	int cycles = 0;
	bit quiet;

	nearest_neighbor_track_table_top DUT (.*);

	nntt_checker checker_i (.*);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// stall the result side in bursts
	always @(negedge clk) begin
		if (quiet || $urandom_range(0, 3) != 0) out_ready <= 1'b1;
		else begin
			out_ready <= 1'b0;
			repeat ($urandom_range(1, 10) - 1) @(negedge clk);
		end
	end

	// valid stays high after acceptance until the next request or a drain
	task automatic send(logic [ACT_W-1:0] a, logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic eob);
		if (!quiet && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action <= a;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		end_of_batch <= eob;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (50) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int n);
		logic signed [15:0] bx, by, bz;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 19);
			bx = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1200));
			by = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1200));
			bz = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 1200));
			if (r < 12) send(ACT_DETECT, bx, by, bz, 1'($urandom_range(0, 1)));
			else if (r < 16) send(ACT_TICK, '0, '0, '0, 1'b0);
			else if (r < 19) send(ACT_REPORT, 16'($urandom), 16'($urandom), 16'($urandom),
				1'($urandom));
			else send(ACT_NONE, 16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		quiet = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		action = ACT_DETECT;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		end_of_batch = 1'b0;
		out_ready = 1'b1;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send(ACT_REPORT, '0, '0, '0, 1'b0);
		send(ACT_DETECT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b0);
		send(ACT_DETECT, 16'sh7fff, 16'sh7fff, 16'sh7fff, 1'b1);
		send(ACT_DETECT, 16'sh7ff0, 16'sh7fff, 16'sh7fff, 1'b1);
		send(ACT_DETECT, -16'sh8000, -16'sh8000, -16'sh8000, 1'b1);
		send(ACT_DETECT, '0, '0, '0, 1'b0);
		send(ACT_DETECT, '0, '0, '0, 1'b1);
		send(ACT_DETECT, 16'sd128, '0, '0, 1'b1);
		send(ACT_DETECT, 16'sd64, '0, '0, 1'b1);
		send(ACT_TICK, '0, '0, '0, 1'b0);
		send(ACT_REPORT, '0, '0, '0, 1'b1);
		send(ACT_NONE, 16'sh1234, '0, '0, 1'b1);
		for (int i = 0; i < 14; i++) send(ACT_DETECT, 16'(i * 3000), -16'(i * 2000),
			16'(i * 1000), 1'b1);
		send(ACT_REPORT, '0, '0, '0, 1'b0);

		write_reg(CFG_RECENT, 34'd0);
		send(ACT_REPORT, '0, '0, '0, 1'b0);
		write_reg(CFG_RADIUS, 34'h3ffffffff);
		write_reg(CFG_STALE, 34'd3);
		write_reg(CFG_RECENT, 34'hffff);
		random_phase(25);
		write_reg(CFG_STALE, 34'd0);
		send(ACT_REPORT, '0, '0, '0, 1'b0);
		write_reg(CFG_RADIUS, 34'd0);
		write_reg(CFG_STALE, 34'hffff);
		write_reg(CFG_RECENT, 34'd4);
		random_phase(25);
		write_reg(CFG_RADIUS, 34'd400000);
		write_reg(CFG_STALE, 34'd6);
		write_reg(CFG_RECENT, 34'd3);
		quiet = 1'b1;
		random_phase(30);

		drain();
		if (fail_count == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end

endmodule
